// File: sv/bal_pkg.sv
// ----------------------------------------------------------------------------
// bal_pkg
// Shared types and constants of the bounded array list: sizes, operation and
// status codes, and the command and status groups between controller and
// datapath.
// ----------------------------------------------------------------------------
package bal_pkg;

  // Store geometry
  localparam int CAPACITY  = 64;
  localparam int WORD_BITS = 32;
  localparam int ADDR_BITS = $clog2(CAPACITY);
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);

  // Field widths of the item ports
  localparam int OP_BITS     = 3;
  localparam int POS_BITS    = 7;
  localparam int VALUE_BITS  = 32;
  localparam int STATUS_BITS = 2;
  localparam int LEN_BITS    = 7;

  // Operation codes
  localparam logic [OP_BITS-1:0] OP_APPEND  = 3'd0;
  localparam logic [OP_BITS-1:0] OP_PREPEND = 3'd1;
  localparam logic [OP_BITS-1:0] OP_INSERT  = 3'd2;
  localparam logic [OP_BITS-1:0] OP_REM_AT  = 3'd3;
  localparam logic [OP_BITS-1:0] OP_REM_VAL = 3'd4;
  localparam logic [OP_BITS-1:0] OP_READ    = 3'd5;

  // Status codes
  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd2;

  typedef logic [CNT_BITS-1:0] cnt_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;     // capture the accepted item and check it
    logic start;    // set up the scan pointers for the operation
    logic step;     // issue one store read and advance the scan pointer
    logic put_new;  // write the new word at the insert position
    logic commit;   // update the length and register the result
  } bal_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic               err;        // item rejected (full or out of range)
    logic               at_end;     // insert lands at the current length
    logic               tail_rm;    // remove at index hits the last entry
    logic               empty;      // no entries stored
    logic               scan_last;  // scan pointer sits on its final entry
  } bal_stat_t;

endpackage

// File: sv/bal_ctrl.sv
// ----------------------------------------------------------------------------
// bal_ctrl
// Controller of the bounded array list: takes one item at a time, steps the
// datapath through its shift or compaction scan and hands out the result.
// ----------------------------------------------------------------------------
module bal_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bal_pkg::bal_stat_t stat,
  output bal_pkg::bal_cmd_t  cmd
);
  import bal_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_PUTNEW = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       is_insert;

  assign is_insert = (stat.op == OP_APPEND) || (stat.op == OP_PREPEND) ||
                     (stat.op == OP_INSERT);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_RESP);

  // Sequence one item through decode, scan and result
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.err) begin
          state_nxt = S_FINISH;
        end else if (is_insert) begin
          if (stat.at_end) begin
            state_nxt = S_PUTNEW;
          end else begin
            cmd.start = 1'b1;
            state_nxt = S_SCAN;
          end
        end else if (stat.op == OP_REM_AT) begin
          if (stat.tail_rm) begin
            state_nxt = S_FINISH;
          end else begin
            cmd.start = 1'b1;
            state_nxt = S_SCAN;
          end
        end else if (stat.op == OP_REM_VAL) begin
          if (stat.empty) begin
            state_nxt = S_FINISH;
          end else begin
            cmd.start = 1'b1;
            state_nxt = S_SCAN;
          end
        end else if (stat.op == OP_READ) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = is_insert ? S_PUTNEW : S_FINISH;
      end
      S_PUTNEW: begin
        cmd.put_new = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_FINISH: begin
        cmd.commit = 1'b1;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A scan never starts on a rejected item
  a_no_scan_on_err: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start |-> !stat.err))
    else $error("scan started for a rejected item");

  // The result shows only after a commit
  a_resp_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid) |-> $past(cmd.commit)))
    else $error("result raised without commit");

  // A new item is taken only once the previous result has gone
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load |=> !in_ready && !out_valid))
    else $error("controller overlapped items");

endmodule

// File: sv/bal_dpath.sv
// ----------------------------------------------------------------------------
// bal_dpath
// Datapath of the bounded array list: entry store with registered read,
// scan pointers, length counter, item checks and the result registers.
// ----------------------------------------------------------------------------
module bal_dpath (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  bal_pkg::bal_cmd_t                      cmd,
  output bal_pkg::bal_stat_t                     stat,
  input  logic        [bal_pkg::OP_BITS-1:0]     in_operation,
  input  logic        [bal_pkg::POS_BITS-1:0]    in_position,
  input  logic signed [bal_pkg::VALUE_BITS-1:0]  in_value,
  output logic        [bal_pkg::STATUS_BITS-1:0] out_status,
  output logic        [bal_pkg::LEN_BITS-1:0]    out_list_length,
  output logic signed [bal_pkg::VALUE_BITS-1:0]  out_read_value,
  output logic        [bal_pkg::LEN_BITS-1:0]    out_removed_count
);
  import bal_pkg::*;

  localparam cnt_t CAP_CNT = CNT_BITS'(CAPACITY);
  localparam cnt_t ONE     = CNT_BITS'(1);

  // Entry store
  logic [WORD_BITS-1:0] mem [CAPACITY];

  // Item registers
  logic [OP_BITS-1:0]     op_r;
  cnt_t                   pos_r;
  cnt_t                   at_r;
  logic [WORD_BITS-1:0]   value_r;
  logic [STATUS_BITS-1:0] status_r;

  // Length and scan state
  cnt_t                 count_r;
  cnt_t                 src_r;
  cnt_t                 end_r;
  logic                 down_r;
  cnt_t                 k_r;
  cnt_t                 removed_r;
  logic                 rd_vld_r;
  cnt_t                 rd_idx_r;
  logic [WORD_BITS-1:0] rd_data_r;

  // Result registers
  logic [STATUS_BITS-1:0] res_status_r;
  cnt_t                   res_len_r;
  logic [WORD_BITS-1:0]   res_read_r;
  cnt_t                   res_removed_r;

  // Check the incoming item against the current length
  logic                   in_is_ins;
  cnt_t                   in_pos;
  cnt_t                   in_at;
  logic [STATUS_BITS-1:0] in_status;

  assign in_is_ins = (in_operation == OP_APPEND) || (in_operation == OP_PREPEND) ||
                     (in_operation == OP_INSERT);
  assign in_pos    = CNT_BITS'(in_position);

  always_comb begin
    priority if (in_operation == OP_APPEND) begin
      in_at = count_r;
    end else if (in_operation == OP_PREPEND) begin
      in_at = '0;
    end else begin
      in_at = in_pos;
    end
  end

  always_comb begin
    in_status = ST_OK;
    priority if (in_is_ins) begin
      if (count_r >= CAP_CNT) begin
        in_status = ST_FULL;
      end else if (in_at > count_r) begin
        in_status = ST_RANGE;
      end
    end else if ((in_operation == OP_REM_AT) || (in_operation == OP_READ)) begin
      if (in_pos >= count_r) begin
        in_status = ST_RANGE;
      end
    end else begin
      in_status = ST_OK;
    end
  end

  // Store write: the new word at its insert position, or pending read data moved up, down or compacted
  logic                 is_ins;
  logic                 wr_en;
  logic [ADDR_BITS-1:0] wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic                 match;
  cnt_t                 idx_up;
  cnt_t                 idx_dn;

  assign is_ins = (op_r == OP_APPEND) || (op_r == OP_PREPEND) || (op_r == OP_INSERT);
  assign match  = (rd_data_r == value_r);
  assign idx_up = rd_idx_r + ONE;
  assign idx_dn = rd_idx_r - ONE;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_idx_r[ADDR_BITS-1:0];
    wr_data = rd_data_r;
    priority if (cmd.put_new) begin
      wr_en   = 1'b1;
      wr_addr = at_r[ADDR_BITS-1:0];
      wr_data = value_r;
    end else if (rd_vld_r && is_ins) begin
      wr_en   = 1'b1;
      wr_addr = idx_up[ADDR_BITS-1:0];
    end else if (rd_vld_r && (op_r == OP_REM_AT)) begin
      wr_en   = 1'b1;
      wr_addr = idx_dn[ADDR_BITS-1:0];
    end else if (rd_vld_r && (op_r == OP_REM_VAL)) begin
      wr_en   = !match;
      wr_addr = k_r[ADDR_BITS-1:0];
    end else begin
      wr_en   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered store read at the scan pointer
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      rd_data_r <= mem[src_r[ADDR_BITS-1:0]];
      rd_idx_r  <= src_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.step;
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_operation;
      pos_r    <= in_pos;
      at_r     <= in_at;
      value_r  <= WORD_BITS'(in_value);
      status_r <= in_status;
    end
  end

  // Set up and advance the scan pointer
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      priority if (is_ins) begin
        src_r  <= count_r - ONE;
        end_r  <= at_r;
        down_r <= 1'b1;
      end else if (op_r == OP_REM_AT) begin
        src_r  <= pos_r + ONE;
        end_r  <= count_r - ONE;
        down_r <= 1'b0;
      end else if (op_r == OP_REM_VAL) begin
        src_r  <= '0;
        end_r  <= count_r - ONE;
        down_r <= 1'b0;
      end else begin
        src_r  <= pos_r;
        end_r  <= pos_r;
        down_r <= 1'b0;
      end
    end else if (cmd.step) begin
      src_r <= down_r ? (src_r - ONE) : (src_r + ONE);
    end
  end

  // Count kept and dropped entries during compaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k_r       <= '0;
      removed_r <= '0;
    end else if (rd_vld_r && (op_r == OP_REM_VAL)) begin
      if (match) begin
        removed_r <= removed_r + ONE;
      end else begin
        k_r <= k_r + ONE;
      end
    end
  end

  // Update the length and register the result
  cnt_t count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (status_r == ST_OK) begin
      priority if (is_ins) begin
        count_nxt = count_r + ONE;
      end else if (op_r == OP_REM_AT) begin
        count_nxt = count_r - ONE;
      end else if (op_r == OP_REM_VAL) begin
        count_nxt = k_r;
      end else begin
        count_nxt = count_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_status_r  <= status_r;
      res_len_r     <= count_nxt;
      res_read_r    <= ((op_r == OP_READ) && (status_r == ST_OK)) ? rd_data_r : '0;
      priority if ((op_r == OP_REM_AT) && (status_r == ST_OK)) begin
        res_removed_r <= ONE;
      end else if (op_r == OP_REM_VAL) begin
        res_removed_r <= removed_r;
      end else begin
        res_removed_r <= '0;
      end
    end
  end

  assign out_status        = res_status_r;
  assign out_list_length   = LEN_BITS'(res_len_r);
  assign out_read_value    = VALUE_BITS'(signed'(res_read_r));
  assign out_removed_count = LEN_BITS'(res_removed_r);

  // Status towards the controller
  assign stat.op        = op_r;
  assign stat.err       = (status_r != ST_OK);
  assign stat.at_end    = (at_r == count_r);
  assign stat.tail_rm   = (pos_r == (count_r - ONE));
  assign stat.empty     = (count_r == '0);
  assign stat.scan_last = (src_r == end_r);

  // The length never passes the capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CAP_CNT))
    else $error("list length above capacity");

  // The length moves only after a commit
  a_count_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (!$past(cmd.commit) |-> $stable(count_r)))
    else $error("list length changed outside commit");

  // Compaction never writes ahead of the entry being read
  a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
    ((rd_vld_r && (op_r == OP_REM_VAL)) |-> (k_r <= rd_idx_r)))
    else $error("compaction write overtook its read");

  // The new word is never written while a moved entry is pending
  a_put_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.put_new |-> !rd_vld_r))
    else $error("insert write collides with a shift write");

endmodule

// File: sv/bounded_array_list.sv
// Sequence: an item without a scan passes decide, finish and result; an insert
// at the tail adds the new-word write; other items walk scan and drain first.
// Throughput: one item at a time; the scan moves one entry per cycle through
// the single read port and single write port of the entry store.
// Reset: synchronous, active low; clears the length and control state. The
// store contents are not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
// bounded_array_list
// Packed ordered list of signed words with append, prepend, insert, remove at
// index, remove by value and read, built as a controller and a datapath.
// ----------------------------------------------------------------------------
module bounded_array_list (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic        [bal_pkg::OP_BITS-1:0]     in_operation,
  input  logic        [bal_pkg::POS_BITS-1:0]    in_position,
  input  logic signed [bal_pkg::VALUE_BITS-1:0]  in_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic        [bal_pkg::STATUS_BITS-1:0] out_status,
  output logic        [bal_pkg::LEN_BITS-1:0]    out_list_length,
  output logic signed [bal_pkg::VALUE_BITS-1:0]  out_read_value,
  output logic        [bal_pkg::LEN_BITS-1:0]    out_removed_count
);
  import bal_pkg::*;

  bal_cmd_t  cmd;
  bal_stat_t stat;

  // Sequence each item
  bal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold the store and compute the result
  bal_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_operation      (in_operation),
    .in_position       (in_position),
    .in_value          (in_value),
    .out_status        (out_status),
    .out_list_length   (out_list_length),
    .out_read_value    (out_read_value),
    .out_removed_count (out_removed_count)
  );

endmodule

// File: bench/bal_list_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bal_list_checker
// Watches both item channels of the bounded array list, keeps a shadow copy
// of the list, works out the result of every accepted item and compares each
// returned result with the oldest one still waiting.
// ----------------------------------------------------------------------------
module bal_list_checker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  input  logic                                   in_ready,
  input  logic        [bal_pkg::OP_BITS-1:0]     in_operation,
  input  logic        [bal_pkg::POS_BITS-1:0]    in_position,
  input  logic signed [bal_pkg::VALUE_BITS-1:0]  in_value,
  input  logic                                   out_valid,
  input  logic                                   out_ready,
  input  logic        [bal_pkg::STATUS_BITS-1:0] out_status,
  input  logic        [bal_pkg::LEN_BITS-1:0]    out_list_length,
  input  logic signed [bal_pkg::VALUE_BITS-1:0]  out_read_value,
  input  logic        [bal_pkg::LEN_BITS-1:0]    out_removed_count,
  output int                                     fail_count,
  output int                                     outstanding,
  output int                                     predicted_length
);
  import bal_pkg::*;

  typedef struct packed {
    logic        [STATUS_BITS-1:0] status;
    logic        [LEN_BITS-1:0]    length;
    logic signed [VALUE_BITS-1:0]  rd;
    logic        [LEN_BITS-1:0]    removed;
  } list_result_t;

  // Shadow of the list; only entries below shadow_len are ever looked at
  logic signed [VALUE_BITS-1:0] shadow_words [CAPACITY];
  int                           shadow_len;
  list_result_t                 pending_results [$];

  // Apply one item to the shadow list and work out its result
  task automatic apply_list_op(input  logic        [OP_BITS-1:0]    op,
                               input  logic        [POS_BITS-1:0]   pos,
                               input  logic signed [VALUE_BITS-1:0] word,
                               output list_result_t                 res);
    int p;
    int at;
    int keep;
    res = '0;
    p   = int'(pos);
    case (op)
      OP_APPEND, OP_PREPEND, OP_INSERT: begin
        at = (op == OP_APPEND) ? shadow_len : (op == OP_PREPEND) ? 0 : p;
        // full check takes precedence over the index check
        if (shadow_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (at > shadow_len) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = shadow_len; i > at; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[at] = word;
          shadow_len++;
        end
      end
      OP_REM_AT: begin
        if (p >= shadow_len) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = p; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
          shadow_len--;
          res.removed = 1;
        end
      end
      OP_REM_VAL: begin
        // compact the survivors in order, counting every match
        keep = 0;
        for (int r = 0; r < shadow_len; r++) begin
          if (shadow_words[r] == word) begin
            res.removed++;
          end else begin
            shadow_words[keep] = shadow_words[r];
            keep++;
          end
        end
        shadow_len = keep;
      end
      OP_READ: begin
        if (p >= shadow_len) res.status = ST_RANGE;
        else res.rd = shadow_words[p];
      end
      default: ;
    endcase
    res.length = shadow_len[LEN_BITS-1:0];
  endtask

  // Check returned results first, then log the newly accepted item
  always @(posedge clk) begin : watch
    list_result_t got;
    list_result_t want;
    if (!rst_n) begin
      shadow_len       = 0;
      fail_count       = 0;
      outstanding      = 0;
      predicted_length = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_status, out_list_length, out_read_value, out_removed_count};
        if (pending_results.size() == 0) begin
          $error("result item with no item outstanding");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.length !== want.length) begin
            $error("list_length: expected %0d, got %0d", want.length, got.length);
            fail_count++;
          end
          if (got.rd !== want.rd) begin
            $error("read_value: expected %0d, got %0d", want.rd, got.rd);
            fail_count++;
          end
          if (got.removed !== want.removed) begin
            $error("removed_count: expected %0d, got %0d", want.removed, got.removed);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_list_op(in_operation, in_position, in_value, want);
        pending_results.push_back(want);
      end
      outstanding      = pending_results.size();
      predicted_length = shadow_len;
    end
  end

endmodule

// File: bench/tb_bounded_array_list.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_array_list
// Drives list operations into the bounded array list: a directed opening over
// the edge cases, then phases of random items that grow the list to full,
// shrink it to empty and mix both, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_bounded_array_list;
  import bal_pkg::*;

  localparam int RANDOM_ITEMS = 1525;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 100;

  // Spare operation codes: the block must leave the list alone
  localparam logic [OP_BITS-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_BITS-1:0] OP_SPARE_HI = 3'd7;

  typedef enum logic [1:0] {PH_GROW, PH_SHRINK, PH_MIX} phase_kind_e;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic        [OP_BITS-1:0]     in_operation;
  logic        [POS_BITS-1:0]    in_position;
  logic signed [VALUE_BITS-1:0]  in_value;
  logic                          out_valid;
  logic                          out_ready;
  logic        [STATUS_BITS-1:0] out_status;
  logic        [LEN_BITS-1:0]    out_list_length;
  logic signed [VALUE_BITS-1:0]  out_read_value;
  logic        [LEN_BITS-1:0]    out_removed_count;

  int                            fail_count;
  int                            outstanding;
  int                            predicted_length;
  int                            sent;
  bit                            calm;
  int                            pool_size;
  logic signed [VALUE_BITS-1:0]  value_pool [4];

  bounded_array_list u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_position      (in_position),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_list_length  (out_list_length),
    .out_read_value   (out_read_value),
    .out_removed_count(out_removed_count)
  );

  bal_list_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_position      (in_position),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_list_length  (out_list_length),
    .out_read_value   (out_read_value),
    .out_removed_count(out_removed_count),
    .fail_count       (fail_count),
    .outstanding      (outstanding),
    .predicted_length (predicted_length)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [OP_BITS-1:0] pick_op(phase_kind_e kind);
    int r;
    int c0, c1, c2, c3, c4, c5, c6;
    r = $urandom_range(0, 99);
    case (kind)
      PH_GROW:   begin c0 = 30; c1 = 48; c2 = 72; c3 = 80; c4 = 85; c5 = 95; c6 = 98; end
      PH_SHRINK: begin c0 = 6;  c1 = 10; c2 = 16; c3 = 55; c4 = 72; c5 = 94; c6 = 97; end
      default:   begin c0 = 15; c1 = 27; c2 = 45; c3 = 62; c4 = 72; c5 = 95; c6 = 98; end
    endcase
    if (r < c0) return OP_APPEND;
    if (r < c1) return OP_PREPEND;
    if (r < c2) return OP_INSERT;
    if (r < c3) return OP_REM_AT;
    if (r < c4) return OP_REM_VAL;
    if (r < c5) return OP_READ;
    if (r < c6) return OP_SPARE_LO;
    return OP_SPARE_HI;
  endfunction

  // Mostly legal indexes; some at the boundary, some anywhere in the field
  function automatic logic [POS_BITS-1:0] pick_position(logic [OP_BITS-1:0] op, int len);
    int r;
    int top_pos;
    r       = $urandom_range(0, 99);
    top_pos = (op == OP_INSERT || len == 0) ? len : len - 1;
    if (r < 85) return POS_BITS'($urandom_range(0, top_pos));
    if (r < 95) return POS_BITS'($urandom_range(0, 127));
    return (r < 98) ? POS_BITS'(len) : POS_BITS'(CAPACITY);
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    if (pool_size == 0) return $urandom;
    return value_pool[$urandom_range(0, pool_size - 1)];
  endfunction

  // Present one item from a falling edge, hold it until taken, then idle for a
  // random gap, which may be zero, unless calm; returns on a falling edge
  task automatic drive_item(input logic        [OP_BITS-1:0]    op,
                            input logic        [POS_BITS-1:0]   pos,
                            input logic signed [VALUE_BITS-1:0] word);
    int gap;
    in_valid     <= 1'b1;
    in_operation <= op;
    in_position  <= pos;
    in_value     <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
  endtask

  // Result side: runs of ready broken by stalls, sometimes a long clean run
  initial begin : result_sink
    int run;
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      gap = pick_gap();
      repeat (run) begin
        @(negedge clk);
        out_ready <= 1'b1;
      end
      repeat (gap) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
    end
  end

  // End the run if neither channel moves an item for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_n);
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_bounded_array_list: errors");
    $finish;
  end

  initial begin : stimulus
    phase_kind_e             kind;
    int                      phase_len;
    logic [OP_BITS-1:0]      op;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = OP_APPEND;
    in_position  = '0;
    in_value     = '0;
    sent         = 0;
    calm         = 1'b0;
    pool_size    = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty list: every index is out of range, nothing to remove
    drive_item(OP_READ,     7'd0,   32'sd0);
    drive_item(OP_REM_AT,   7'd0,   32'sd0);
    drive_item(OP_REM_VAL,  7'd0,   32'sd0);
    drive_item(OP_INSERT,   7'd1,   32'sd1);
    drive_item(OP_SPARE_LO, 7'd127, -32'sd1);
    drive_item(OP_SPARE_HI, 7'd64,  32'sh5555_5555);
    // Build up with the extreme words
    drive_item(OP_APPEND,   7'd127, 32'sh7FFF_FFFF);
    drive_item(OP_APPEND,   7'd0,   32'sh8000_0000);
    drive_item(OP_PREPEND,  7'd99,  -32'sd1);
    drive_item(OP_INSERT,   7'd3,   32'sh5555_5555);
    drive_item(OP_INSERT,   7'd0,   32'sd0);
    drive_item(OP_INSERT,   7'd2,   32'shAAAA_AAAA);
    drive_item(OP_INSERT,   7'd7,   32'sd3);
    drive_item(OP_INSERT,   7'd127, 32'sd3);
    // Reads at both ends and past them
    drive_item(OP_READ,     7'd0,   32'sd0);
    drive_item(OP_READ,     7'd5,   32'sd0);
    drive_item(OP_READ,     7'd6,   32'sd0);
    drive_item(OP_READ,     7'd127, 32'sd0);
    // Remove the tail, the head, then one past the end
    drive_item(OP_REM_AT,   7'd5,   32'sd0);
    drive_item(OP_REM_AT,   7'd0,   32'sd0);
    drive_item(OP_REM_AT,   7'd4,   32'sd0);
    // Neighbouring and separated matches go in one pass
    drive_item(OP_APPEND,   7'd0,   32'sd5);
    drive_item(OP_APPEND,   7'd0,   32'sd5);
    drive_item(OP_PREPEND,  7'd0,   32'sd5);
    drive_item(OP_REM_VAL,  7'd0,   32'sd5);
    drive_item(OP_REM_VAL,  7'd0,   32'sd5);
    drive_item(OP_REM_VAL,  7'd0,   32'sh8000_0000);

    // Random phases: grow to full, shrink to empty, or mix
    while (sent < RANDOM_ITEMS) begin
      kind      = phase_kind_e'($urandom_range(0, 2));
      phase_len = $urandom_range(40, 160);
      calm      = ($urandom_range(0, 3) == 0);
      pool_size = $urandom_range(0, 4);
      value_pool[0] = $urandom;
      value_pool[1] = ($urandom_range(0, 1) == 0) ? 32'sh8000_0000 : -32'sd1;
      value_pool[2] = ($urandom_range(0, 1) == 0) ? 32'sh7FFF_FFFF : 32'sd0;
      value_pool[3] = $urandom;
      for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        op = pick_op(kind);
        drive_item(op, pick_position(op, predicted_length), pick_value());
      end
    end
    in_valid <= 1'b0;

    // Drain every expected result, then allow for the longest scan
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_bounded_array_list: clean");
    end else begin
      $display("tb_bounded_array_list: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/bal_pkg.sv
sv/bal_ctrl.sv
sv/bal_dpath.sv
sv/bounded_array_list.sv
bench/bal_list_checker.sv
bench/tb_bounded_array_list.sv
